// ===== rtl/core/alc_pkg.sv =====
// shared constants, types and helper functions for the antenna look-angle core
package alc_pkg;

  localparam int DATA_W = 40;
  localparam int KINV_W = 24;
  localparam logic [KINV_W-1:0] KINV = 24'd10188014;
  localparam int EARTH_R = 6371000;
  localparam int MDEG_TURN = 360000;
  localparam int UDEG_TURN = 360000000;
  localparam int MDEG_QUARTER = 90000;

  // microdegree to binary angle: floor((a*2^24 + ANG_BIAS) / ANG_DEN)
  // done as base-256 long division, each digit by reciprocal multiply
  localparam int ANG_DEN_W = 21;
  localparam logic [ANG_DEN_W-1:0] ANG_DEN = 21'd1406250;
  localparam logic [28:0] ANG_BIAS = 29'd703125;
  // ceil(2^50 / ANG_DEN), exact quotient for dividends below 2^29
  localparam logic [29:0] ANG_RECIP = 30'd800639934;

  typedef enum logic [1:0] {
    REG_LAT = 2'd0,
    REG_LON = 2'd1,
    REG_HGT = 2'd2
  } reg_idx_e;

  typedef enum logic {
    CONV_IDLE,
    CONV_BUSY
  } conv_state_e;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // a * KINV, half lsb added, then arithmetic shift right by s
  function automatic logic signed [DATA_W-1:0] mul_kinv(input logic signed [DATA_W-1:0] a,
                                                        input int s);
    logic signed [DATA_W+KINV_W:0] p;
    logic signed [DATA_W+KINV_W:0] half;
    logic signed [DATA_W+KINV_W:0] sh;
    half = '0;
    half[s-1] = 1'b1;
    p = a * $signed({1'b0, KINV});
    sh = (p + half) >>> s;
    return sh[DATA_W-1:0];
  endfunction

  // angle in microdegrees brought into one turn
  function automatic logic [28:0] udeg_reduce(input logic signed [28:0] a);
    logic signed [30:0] t;
    t = 31'(a);
    if (t < 0) t = t + 31'(UDEG_TURN);
    if (t >= 31'(UDEG_TURN)) t = t - 31'(UDEG_TURN);
    return t[28:0];
  endfunction

endpackage

// ===== rtl/core/alc_angle_conv.sv =====
// converts station latitude and longitude into negated binary rotation angles
module alc_angle_conv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [27:0] lat_i,
  input  logic [28:0] lon_i,
  output logic        busy_o,
  output logic [31:0] lat_rot_o,
  output logic [31:0] lon_rot_o
);

  alc_pkg::conv_state_e state_q, state_d;
  logic        phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [28:0] t_q, t_d;
  logic [8:0]  dig_q, dig_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] lat_rot_q, lat_rot_d;
  logic [31:0] lon_rot_q, lon_rot_d;
  logic [28:0] lat_red, lon_red, t_cur;
  logic [58:0] prod;
  logic [28:0] rem;
  logic [31:0] acc_nxt;

  assign lat_red = alc_pkg::udeg_reduce({lat_i[27], lat_i});
  assign lon_red = alc_pkg::udeg_reduce(lon_i);

  // cnt: bits [2:1] pick the base-256 digit, bit 0 is multiply then remainder
  assign t_cur   = (cnt_q == 3'd0) ? (phase_q ? lat_red : lon_red) : t_q;
  assign prod    = t_cur * alc_pkg::ANG_RECIP;
  assign rem     = t_q - 29'(dig_q) * 29'(alc_pkg::ANG_DEN);
  assign acc_nxt = ((cnt_q[2:1] == 2'd0) ? 32'd0 : {acc_q[23:0], 8'd0}) + 32'(dig_q);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    t_d       = t_q;
    dig_d     = dig_q;
    acc_d     = acc_q;
    lat_rot_d = lat_rot_q;
    lon_rot_d = lon_rot_q;
    case (state_q)
      alc_pkg::CONV_IDLE: begin
      end
      alc_pkg::CONV_BUSY: begin
        cnt_d = cnt_q + 3'd1;
        if (!cnt_q[0]) begin
          t_d   = t_cur;
          dig_d = prod[58:50];
        end else begin
          acc_d = acc_nxt;
          if (cnt_q[2:1] == 2'd3) begin
            if (!phase_q) begin
              lon_rot_d = 32'd0 - acc_nxt;
              phase_d   = 1'b1;
            end else begin
              lat_rot_d = 32'd0 - acc_nxt;
              state_d   = alc_pkg::CONV_IDLE;
            end
          end else if (cnt_q[2:1] == 2'd2) begin
            // rounding half enters with the last digit
            t_d = {rem[20:0], 8'd0} + alc_pkg::ANG_BIAS;
          end else begin
            t_d = {rem[20:0], 8'd0};
          end
        end
      end
      default: state_d = alc_pkg::CONV_IDLE;
    endcase
    // a new write restarts both conversions
    if (start_i) begin
      state_d = alc_pkg::CONV_BUSY;
      phase_d = 1'b0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= alc_pkg::CONV_IDLE;
      phase_q   <= 1'b0;
      cnt_q     <= '0;
      lat_rot_q <= '0;
      lon_rot_q <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      lat_rot_q <= lat_rot_d;
      lon_rot_q <= lon_rot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    dig_q <= dig_d;
    acc_q <= acc_d;
  end

  assign busy_o    = (state_q == alc_pkg::CONV_BUSY);
  assign lat_rot_o = lat_rot_q;
  assign lon_rot_o = lon_rot_q;

endmodule

// ===== rtl/core/alc_cordic_rot.sv =====
// pipelined cordic rotation, one micro-rotation per stage
module alc_cordic_rot #(
  parameter int STEPS  = 24,
  parameter int SIDE_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [alc_pkg::DATA_W-1:0]  x_i,
  input  logic signed [alc_pkg::DATA_W-1:0]  y_i,
  input  logic [31:0]                        ang_i,
  input  logic [SIDE_W-1:0]                  side_i,
  output logic                               valid_o,
  output logic signed [alc_pkg::DATA_W-1:0]  x_o,
  output logic signed [alc_pkg::DATA_W-1:0]  y_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int W = alc_pkg::DATA_W;

  logic [STEPS:0]         vld_q;
  logic signed [W-1:0]    x_q [0:STEPS];
  logic signed [W-1:0]    y_q [0:STEPS];
  logic signed [32:0]     z_q [0:STEPS];
  logic [SIDE_W-1:0]      side_q [0:STEPS];
  logic signed [32:0]     z_in;

  assign z_in = $signed({ang_i[31], ang_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  // fold into +-90 degrees by negating the vector
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      if (z_in > 33'sh040000000) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= z_in - 33'sh080000000;
      end else if (z_in < -33'sh040000000) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= z_in + 33'sh080000000;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= z_in;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({1'b0, alc_pkg::atan_entry(i)});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({1'b0, alc_pkg::atan_entry(i)});
        end
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign x_o     = x_q[STEPS];
  assign y_o     = y_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule

// ===== rtl/core/alc_cordic_vec.sv =====
// pipelined cordic vectoring, gives magnitude and binary angle of (x, y)
module alc_cordic_vec #(
  parameter int STEPS  = 24,
  parameter int SIDE_W = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [alc_pkg::DATA_W-1:0]  x_i,
  input  logic signed [alc_pkg::DATA_W-1:0]  y_i,
  input  logic [SIDE_W-1:0]                  side_i,
  output logic                               valid_o,
  output logic signed [alc_pkg::DATA_W-1:0]  mag_o,
  output logic [31:0]                        ang_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int W = alc_pkg::DATA_W;

  logic [STEPS:0]         vld_q;
  logic signed [W-1:0]    x_q [0:STEPS];
  logic signed [W-1:0]    y_q [0:STEPS];
  logic signed [32:0]     z_q [0:STEPS];
  logic [STEPS:0]         half_q;
  logic [SIDE_W-1:0]      side_q [0:STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  // left half plane: negate and add half a turn at the end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      z_q[0]    <= '0;
      half_q[0] <= x_i < 0;
      x_q[0]    <= (x_i < 0) ? -x_i : x_i;
      y_q[0]    <= (x_i < 0) ? -y_i : y_i;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        half_q[i+1] <= half_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({1'b0, alc_pkg::atan_entry(i)});
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({1'b0, alc_pkg::atan_entry(i)});
        end
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign mag_o   = x_q[STEPS];
  assign ang_o   = {half_q[STEPS], 31'd0} + z_q[STEPS][31:0];
  assign side_o  = side_q[STEPS];

endmodule

// ===== rtl/core/antenna_look_angle.sv =====
// top level of the antenna look-angle core: config registers and the main pipeline
//
// slave stream: one word per satellite earth-fixed position (x, y, z in meters).
// master stream: one word per input, dish azimuth and elevation in millidegrees.
// apb port: station latitude (0x0), longitude (0x4), height (0x8); reads return
// the stored values. after a latitude or longitude write the station angles are
// recomputed by a digit-wise reciprocal-multiply divider, during which
// s_axis_tready is low; a height write takes effect at once.
// the main pipeline has four cordic chains of CORDIC_STEPS+1 stages each plus six
// multiply and fix-up stages. throughput is one word per cycle except during a
// station angle update or an output stall; every stage is registered.
// when the receiver holds m_axis_tready low with a word pending, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
// reset clears the registers to zero (station on the equator at zero longitude,
// height zero) and empties the pipeline.
module antenna_look_angle #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sat_x [26:0], sat_y [53:27], sat_z [80:54], zero fill
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // azimuth [18:0], elevation [36:19], zero fill
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W = alc_pkg::DATA_W;

  logic [27:0] lat_q;
  logic [28:0] lon_q;
  logic [14:0] hgt_q;
  logic        wr_en, ang_wr;
  logic        conv_busy;
  logic [31:0] lat_rot, lon_rot;
  logic        en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign ang_wr = wr_en & ((paddr[3:2] == alc_pkg::REG_LAT) | (paddr[3:2] == alc_pkg::REG_LON));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
      lon_q <= '0;
      hgt_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        alc_pkg::REG_LAT: lat_q <= pwdata[27:0];
        alc_pkg::REG_LON: lon_q <= pwdata[28:0];
        alc_pkg::REG_HGT: hgt_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      alc_pkg::REG_LAT: prdata = {4'd0, lat_q};
      alc_pkg::REG_LON: prdata = {3'd0, lon_q};
      alc_pkg::REG_HGT: prdata = {17'd0, hgt_q};
      default:          prdata = '0;
    endcase
  end

  alc_angle_conv u_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ang_wr),
    .lat_i     (lat_q),
    .lon_i     (lon_q),
    .busy_o    (conv_busy),
    .lat_rot_o (lat_rot),
    .lon_rot_o (lon_rot)
  );

  logic vout_q;
  assign en            = ~vout_q | m_axis_tready;
  assign s_axis_tready = en & ~conv_busy;

  // stage 1: scale by inverse cordic gain into q.8
  logic                v1_q;
  logic signed [W-1:0] x1_q, y1_q, z1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid & ~conv_busy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= alc_pkg::mul_kinv({{(W-27){s_axis_tdata[26]}}, s_axis_tdata[26:0]}, 16);
      y1_q <= alc_pkg::mul_kinv({{(W-27){s_axis_tdata[53]}}, s_axis_tdata[53:27]}, 16);
      z1_q <= alc_pkg::mul_kinv({{(W-27){s_axis_tdata[80]}}, s_axis_tdata[80:54]}, 16);
    end
  end

  // rotate about z by -longitude
  logic                v_r1;
  logic signed [W-1:0] p_r1, east_r1;
  logic [W-1:0]        z_r1;

  alc_cordic_rot #(.STEPS(CORDIC_STEPS), .SIDE_W(W)) u_rot_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .x_i     (x1_q),
    .y_i     (y1_q),
    .ang_i   (lon_rot),
    .side_i  (z1_q),
    .valid_o (v_r1),
    .x_o     (p_r1),
    .y_o     (east_r1),
    .side_o  (z_r1)
  );

  // stage 2: rescale p
  logic                v2_q;
  logic signed [W-1:0] p2_q, east2_q, z2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v_r1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q    <= alc_pkg::mul_kinv(p_r1, 24);
      east2_q <= east_r1;
      z2_q    <= z_r1;
    end
  end

  // rotate in the meridian plane by -latitude
  logic                v_r2;
  logic signed [W-1:0] u_r2, north_r2;
  logic [W-1:0]        east_r2;

  alc_cordic_rot #(.STEPS(CORDIC_STEPS), .SIDE_W(W)) u_rot_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .x_i     (p2_q),
    .y_i     (z2_q),
    .ang_i   (lat_rot),
    .side_i  (east2_q),
    .valid_o (v_r2),
    .x_o     (u_r2),
    .y_o     (north_r2),
    .side_o  (east_r2)
  );

  // stage 3: subtract station radius, flag zero horizontal offset
  logic                v3_q;
  logic signed [W-1:0] north3_q, east3_q, up3_q;
  logic                nz3_q;
  logic signed [W-1:0] rbase;

  assign rbase = (W'(alc_pkg::EARTH_R) + {{(W-15){hgt_q[14]}}, hgt_q}) <<< 8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v_r2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      north3_q <= north_r2;
      east3_q  <= east_r2;
      up3_q    <= u_r2 - rbase;
      nz3_q    <= (east_r2 == '0) && (north_r2 == '0);
    end
  end

  // azimuth vectoring on (north, east)
  logic                v_v1;
  logic signed [W-1:0] hmag_v1;
  logic [31:0]         b_v1;
  logic [W:0]          side_v1;

  alc_cordic_vec #(.STEPS(CORDIC_STEPS), .SIDE_W(W+1)) u_vec_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .x_i     (north3_q),
    .y_i     (east3_q),
    .side_i  ({nz3_q, up3_q}),
    .valid_o (v_v1),
    .mag_o   (hmag_v1),
    .ang_o   (b_v1),
    .side_o  (side_v1)
  );

  // stage 4: horizontal magnitude and azimuth scaling product
  logic                v4_q;
  logic signed [W-1:0] h4_q, up4_q;
  logic                nz4_q;
  logic [51:0]         azp4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v_v1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h4_q   <= side_v1[W] ? '0 : alc_pkg::mul_kinv(hmag_v1, 24);
      up4_q  <= side_v1[W-1:0];
      nz4_q  <= side_v1[W];
      azp4_q <= 52'(b_v1) * 52'(alc_pkg::MDEG_TURN) + 52'h0_8000_0000;
    end
  end

  logic [19:0] az_raw;
  logic [18:0] az4;
  logic        ez4;

  assign az_raw = azp4_q[51:32];
  assign az4    = (nz4_q || (az_raw >= 20'(alc_pkg::MDEG_TURN))) ? '0 : az_raw[18:0];
  assign ez4    = (h4_q == '0) && (up4_q == '0);

  // elevation vectoring on (horizontal, up)
  logic                v_v2;
  logic signed [W-1:0] mag_v2;
  logic [31:0]         b_v2;
  logic [19:0]         side_v2;

  alc_cordic_vec #(.STEPS(CORDIC_STEPS), .SIDE_W(20)) u_vec_el (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .x_i     (h4_q),
    .y_i     (up4_q),
    .side_i  ({ez4, az4}),
    .valid_o (v_v2),
    .mag_o   (mag_v2),
    .ang_o   (b_v2),
    .side_o  (side_v2)
  );

  // stage 5: elevation scaling product (magnitude of the last vectoring unused)
  logic               v6_q;
  logic signed [51:0] ep6_q;
  logic [19:0]        side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v_v2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ep6_q   <= $signed({{20{b_v2[31]}}, b_v2}) * $signed(52'(alc_pkg::MDEG_TURN))
                 + $signed(52'h0_8000_0000) + 52'(mag_v2 & '0);
      side6_q <= side_v2;
    end
  end

  // stage 6: output register with clamp
  logic [18:0]        az_q;
  logic [17:0]        el_q;
  logic signed [19:0] el_raw;
  logic [17:0]        el_d;

  assign el_raw = ep6_q[51:32];

  always_comb begin
    if (side6_q[19]) el_d = '0;
    else if (el_raw > 20'(alc_pkg::MDEG_QUARTER)) el_d = 18'(alc_pkg::MDEG_QUARTER);
    else if (el_raw < -20'(alc_pkg::MDEG_QUARTER)) el_d = -18'(alc_pkg::MDEG_QUARTER);
    else el_d = el_raw[17:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vout_q <= 1'b0;
    else if (en) vout_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      az_q <= side6_q[18:0];
      el_q <= el_d;
    end
  end

  assign m_axis_tvalid = vout_q;
  assign m_axis_tdata  = {3'd0, el_q, az_q};

endmodule

// ===== rtl/core/alc_checker.sv =====
// port-level checks for the antenna look-angle core, bound to the top level
module alc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_az_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[18:0] < 19'd360000)
    else $error("azimuth out of range");

  a_el_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[36:19]) <= 18'sd90000) &&
                      ($signed(m_axis_tdata[36:19]) >= -18'sd90000))
    else $error("elevation out of range");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite &&
    ((paddr[3:2] == alc_pkg::REG_LAT) || (paddr[3:2] == alc_pkg::REG_LON))
    |=> !s_axis_tready)
    else $error("input taken during station angle update");

endmodule

bind antenna_look_angle alc_checker u_alc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr)
);
